>>> sv/ptb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Piece table text buffer package
// Request and result types, request and status codes, sequencer states.
// ----------------------------------------------------------------------------
package ptb_pkg;

    localparam int LEN_W   = 14;
    localparam int DOC_MAX = 8192;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_READ   = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_BYTE_FULL = 2'd2,
        ST_TBL_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [12:0] position;
        logic [7:0]  data_byte;
        logic        start_of_run;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       read_byte;
        logic [LEN_W-1:0] doc_length;
    } t_res;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DEC, S_LD_CLR, S_LD_CHK, S_LD_RD, S_RUN_RD,
        S_SC_RD, S_SC_CMP, S_DISP, S_SH_RD, S_SH_WR, S_W0, S_W1, S_W2,
        S_RD_ST, S_FIN
    } t_state;

endpackage
`default_nettype wire

>>> sv/piece_table_text_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Piece table text buffer
// Original store, append-only add store and an ordered piece table, edited
// one byte per request by a small sequencer over one table port.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high until
// its result has been shown. Each result appears for one cycle with o_done and
// cannot be held off. Insert, delete and read requests that need a table walk
// read the pieces up to and including the target piece, and an entry shift
// then moves each later piece, all through the single piece table port.
// After reset the block initializes the first table entry before it goes
// idle.
module piece_table_text_buffer #(
    parameter int ORIG_DEPTH  = 4096,
    parameter int ADD_DEPTH   = 4096,
    parameter int PIECE_DEPTH = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    input  wire ptb_pkg::t_req i_req,
    output logic              busy,
    output logic              o_done,
    output ptb_pkg::t_res     o_res
);
    import ptb_pkg::*;

    localparam int OW  = $clog2(ORIG_DEPTH);
    localparam int OFW = $clog2(ORIG_DEPTH + 1);
    localparam int AW  = $clog2(ADD_DEPTH);
    localparam int AFW = $clog2(ADD_DEPTH + 1);
    localparam int SW  = (OFW > AFW) ? OFW : AFW;
    localparam int EW  = ((SW > LEN_W) ? SW : LEN_W) + 1;
    localparam int PW  = $clog2(PIECE_DEPTH);
    localparam int CW  = $clog2(PIECE_DEPTH + 1);

    typedef struct packed {
        logic          src;
        logic [SW-1:0] start;
        logic [LEN_W-1:0] len;
    } t_ent;

    t_ent       pt_mem [PIECE_DEPTH];
    logic [7:0] os_mem [ORIG_DEPTH];
    logic [7:0] as_mem [ADD_DEPTH];

    t_state           r_state, n_state;
    t_req             r_req, n_req;
    logic [1:0]       r_stat, n_stat;
    logic [7:0]       r_rbyte, n_rbyte;
    logic [LEN_W-1:0] r_doc, n_doc;
    logic [CW-1:0]    r_count, n_count;
    logic [OFW-1:0]   r_ofill, n_ofill;
    logic [AFW-1:0]   r_afill, n_afill;
    logic [PW-1:0]    r_run_piece, n_run_piece;
    logic             r_run, n_run;
    logic [PW-1:0]    r_i, n_i;
    logic [LEN_W-1:0] r_acc, n_acc;
    logic [PW-1:0]    r_k, n_k;
    logic [LEN_W-1:0] r_off, n_off;
    t_ent             r_ent, n_ent;
    logic [1:0]       r_n, n_n;
    logic [CW-1:0]    r_j, n_j;
    logic             r_idx_ok, n_idx_ok;

    logic          pt_we;
    logic [PW-1:0] pt_wa, pt_ra;
    t_ent          pt_wd, r_pt_q;
    logic          os_we, as_we;
    logic [OW-1:0] os_ra;
    logic [AW-1:0] as_ra;
    logic [7:0]    r_os_q, r_as_q;

    logic [LEN_W:0]   sc_end;
    logic [SW-1:0]    idx;
    logic [CW:0]      cnt_p1, cnt_p2;
    logic             cont;
    logic [CW:0]      sh_dst;

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            pt_mem[pt_wa] <= pt_wd;
        end
        r_pt_q <= pt_mem[pt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (os_we) begin
            os_mem[r_ofill[OW-1:0]] <= r_req.data_byte;
        end
        r_os_q <= os_mem[os_ra];
    end

    always_ff @(posedge i_clk) begin
        if (as_we) begin
            as_mem[r_afill[AW-1:0]] <= r_req.data_byte;
        end
        r_as_q <= as_mem[as_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_doc       <= '0;
            r_count     <= CW'(1);
            r_ofill     <= '0;
            r_afill     <= '0;
            r_run_piece <= '0;
            r_run       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_doc       <= n_doc;
            r_count     <= n_count;
            r_ofill     <= n_ofill;
            r_afill     <= n_afill;
            r_run_piece <= n_run_piece;
            r_run       <= n_run;
        end
        r_req    <= n_req;
        r_stat   <= n_stat;
        r_rbyte  <= n_rbyte;
        r_i      <= n_i;
        r_acc    <= n_acc;
        r_k      <= n_k;
        r_off    <= n_off;
        r_ent    <= n_ent;
        r_n      <= n_n;
        r_j      <= n_j;
        r_idx_ok <= n_idx_ok;
    end

    assign sc_end = {1'b0, r_acc} + {1'b0, r_pt_q.len};
    assign idx    = r_ent.start + SW'(r_off);
    assign cnt_p1 = {1'b0, r_count} + (CW+1)'(1);
    assign cnt_p2 = {1'b0, r_count} + (CW+1)'(2);
    assign cont   = !r_req.start_of_run && r_run && (CW'(r_run_piece) < r_count);
    assign sh_dst = {1'b0, r_j} - (CW+1)'(1) + (CW+1)'(r_n);
    assign os_ra  = idx[OW-1:0];
    assign as_ra  = idx[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_stat      = r_stat;
        n_rbyte     = r_rbyte;
        n_doc       = r_doc;
        n_count     = r_count;
        n_ofill     = r_ofill;
        n_afill     = r_afill;
        n_run_piece = r_run_piece;
        n_run       = r_run;
        n_i         = r_i;
        n_acc       = r_acc;
        n_k         = r_k;
        n_off       = r_off;
        n_ent       = r_ent;
        n_n         = r_n;
        n_j         = r_j;
        n_idx_ok    = r_idx_ok;
        pt_we       = 1'b0;
        pt_wa       = '0;
        pt_wd       = '0;
        pt_ra       = '0;
        os_we       = 1'b0;
        as_we       = 1'b0;

        unique case (r_state)
            S_INIT: begin
                pt_we   = 1'b1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_stat  = ST_OK;
                    n_rbyte = '0;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                unique case (t_req_type'(r_req.req_type))
                    REQ_LOAD: begin
                        n_run = 1'b0;
                        if (r_req.start_of_run) begin
                            n_count     = CW'(1);
                            n_ofill     = '0;
                            n_afill     = '0;
                            n_doc       = '0;
                            n_run_piece = '0;
                            n_state     = S_LD_CLR;
                        end else begin
                            n_state = S_LD_CHK;
                        end
                    end
                    REQ_INSERT: begin
                        priority if (!cont &&
                                     (LEN_W'(r_req.position) > r_doc)) begin
                            n_stat  = ST_BAD_POS;
                            n_state = S_FIN;
                        end else if ((r_afill >= AFW'(ADD_DEPTH)) ||
                                     (r_doc >= LEN_W'(DOC_MAX))) begin
                            n_stat  = ST_BYTE_FULL;
                            n_state = S_FIN;
                        end else if (cont) begin
                            pt_ra   = r_run_piece;
                            n_state = S_RUN_RD;
                        end else if (LEN_W'(r_req.position) == r_doc) begin
                            if (cnt_p1 > (CW+1)'(PIECE_DEPTH)) begin
                                n_stat = ST_TBL_FULL;
                            end else begin
                                pt_we       = 1'b1;
                                pt_wa       = r_count[PW-1:0];
                                pt_wd       = '{1'b1, SW'(r_afill), LEN_W'(1)};
                                as_we       = 1'b1;
                                n_afill     = r_afill + AFW'(1);
                                n_doc       = r_doc + LEN_W'(1);
                                n_count     = r_count + CW'(1);
                                n_run_piece = r_count[PW-1:0];
                                n_run       = 1'b1;
                            end
                            n_state = S_FIN;
                        end else begin
                            n_i     = '0;
                            n_acc   = '0;
                            n_state = S_SC_RD;
                        end
                    end
                    REQ_DELETE: begin
                        n_run = 1'b0;
                        if (LEN_W'(r_req.position) >= r_doc) begin
                            n_stat  = ST_BAD_POS;
                            n_state = S_FIN;
                        end else begin
                            n_i     = '0;
                            n_acc   = '0;
                            n_state = S_SC_RD;
                        end
                    end
                    REQ_READ: begin
                        if (LEN_W'(r_req.position) >= r_doc) begin
                            n_stat  = ST_BAD_POS;
                            n_state = S_FIN;
                        end else begin
                            n_i     = '0;
                            n_acc   = '0;
                            n_state = S_SC_RD;
                        end
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_LD_CLR: begin
                pt_we   = 1'b1;
                n_state = S_LD_CHK;
            end
            S_LD_CHK: begin
                if ((r_ofill >= OFW'(ORIG_DEPTH)) || (r_doc >= LEN_W'(DOC_MAX))) begin
                    n_stat  = ST_BYTE_FULL;
                    n_state = S_FIN;
                end else begin
                    pt_ra   = PW'(r_count - CW'(1));
                    n_state = S_LD_RD;
                end
            end
            S_LD_RD: begin
                n_state = S_FIN;
                if (!r_pt_q.src &&
                    (EW'(r_pt_q.start) + EW'(r_pt_q.len) == EW'(r_ofill))) begin
                    pt_we   = 1'b1;
                    pt_wa   = PW'(r_count - CW'(1));
                    pt_wd   = '{r_pt_q.src, r_pt_q.start, r_pt_q.len + LEN_W'(1)};
                    os_we   = 1'b1;
                    n_ofill = r_ofill + OFW'(1);
                    n_doc   = r_doc + LEN_W'(1);
                end else if (r_count >= CW'(PIECE_DEPTH)) begin
                    n_stat = ST_TBL_FULL;
                end else begin
                    pt_we   = 1'b1;
                    pt_wa   = r_count[PW-1:0];
                    pt_wd   = '{1'b0, SW'(r_ofill), LEN_W'(1)};
                    os_we   = 1'b1;
                    n_ofill = r_ofill + OFW'(1);
                    n_doc   = r_doc + LEN_W'(1);
                    n_count = r_count + CW'(1);
                end
            end
            S_RUN_RD: begin
                pt_we   = 1'b1;
                pt_wa   = r_run_piece;
                pt_wd   = '{r_pt_q.src, r_pt_q.start, r_pt_q.len + LEN_W'(1)};
                as_we   = 1'b1;
                n_afill = r_afill + AFW'(1);
                n_doc   = r_doc + LEN_W'(1);
                n_state = S_FIN;
            end
            S_SC_RD: begin
                pt_ra   = r_i;
                n_state = S_SC_CMP;
            end
            S_SC_CMP: begin
                if ((LEN_W+1)'(r_req.position) < sc_end) begin
                    n_k     = r_i;
                    n_off   = LEN_W'(r_req.position) - r_acc;
                    n_ent   = r_pt_q;
                    n_state = S_DISP;
                end else begin
                    n_acc   = r_acc + r_pt_q.len;
                    n_i     = r_i + PW'(1);
                    n_state = S_SC_RD;
                end
            end
            S_DISP: begin
                n_j = r_count;
                unique case (t_req_type'(r_req.req_type))
                    REQ_INSERT: begin
                        if (r_off == '0) begin
                            if (cnt_p1 > (CW+1)'(PIECE_DEPTH)) begin
                                n_stat  = ST_TBL_FULL;
                                n_state = S_FIN;
                            end else begin
                                n_n     = 2'd1;
                                n_state = S_SH_RD;
                            end
                        end else begin
                            if (cnt_p2 > (CW+1)'(PIECE_DEPTH)) begin
                                n_stat  = ST_TBL_FULL;
                                n_state = S_FIN;
                            end else begin
                                n_n     = 2'd2;
                                n_state = S_SH_RD;
                            end
                        end
                    end
                    REQ_DELETE: begin
                        priority if (r_off == '0) begin
                            pt_we   = 1'b1;
                            pt_wa   = r_k;
                            pt_wd   = '{r_ent.src, r_ent.start + SW'(1),
                                        r_ent.len - LEN_W'(1)};
                            n_doc   = r_doc - LEN_W'(1);
                            n_state = S_FIN;
                        end else if (r_off == r_ent.len - LEN_W'(1)) begin
                            pt_we   = 1'b1;
                            pt_wa   = r_k;
                            pt_wd   = '{r_ent.src, r_ent.start, r_ent.len - LEN_W'(1)};
                            n_doc   = r_doc - LEN_W'(1);
                            n_state = S_FIN;
                        end else if (cnt_p1 > (CW+1)'(PIECE_DEPTH)) begin
                            n_stat  = ST_TBL_FULL;
                            n_state = S_FIN;
                        end else begin
                            n_n     = 2'd1;
                            n_state = S_SH_RD;
                        end
                    end
                    default: begin
                        if (r_ent.src) begin
                            n_idx_ok = (SW+1)'(idx) < (SW+1)'(ADD_DEPTH);
                        end else begin
                            n_idx_ok = (SW+1)'(idx) < (SW+1)'(ORIG_DEPTH);
                        end
                        n_state = S_RD_ST;
                    end
                endcase
            end
            S_SH_RD: begin
                if (r_j > CW'(r_k)) begin
                    pt_ra   = PW'(r_j - CW'(1));
                    n_state = S_SH_WR;
                end else begin
                    n_state = S_W0;
                end
            end
            S_SH_WR: begin
                pt_we   = 1'b1;
                pt_wa   = sh_dst[PW-1:0];
                pt_wd   = r_pt_q;
                n_j     = r_j - CW'(1);
                n_state = S_SH_RD;
            end
            S_W0: begin
                n_count = r_count + CW'(r_n);
                pt_we   = 1'b1;
                pt_wa   = r_k;
                if (r_req.req_type == REQ_INSERT && r_off == '0) begin
                    pt_wd       = '{1'b1, SW'(r_afill), LEN_W'(1)};
                    as_we       = 1'b1;
                    n_afill     = r_afill + AFW'(1);
                    n_doc       = r_doc + LEN_W'(1);
                    n_run_piece = r_k;
                    n_run       = 1'b1;
                    n_state     = S_FIN;
                end else begin
                    pt_wd   = '{r_ent.src, r_ent.start, r_off};
                    n_state = S_W1;
                end
            end
            S_W1: begin
                pt_we = 1'b1;
                pt_wa = r_k + PW'(1);
                if (r_req.req_type == REQ_INSERT) begin
                    pt_wd       = '{1'b1, SW'(r_afill), LEN_W'(1)};
                    as_we       = 1'b1;
                    n_afill     = r_afill + AFW'(1);
                    n_doc       = r_doc + LEN_W'(1);
                    n_run_piece = r_k + PW'(1);
                    n_run       = 1'b1;
                    n_state     = S_W2;
                end else begin
                    pt_wd   = '{r_ent.src, idx + SW'(1),
                                r_ent.len - r_off - LEN_W'(1)};
                    n_doc   = r_doc - LEN_W'(1);
                    n_state = S_FIN;
                end
            end
            S_W2: begin
                pt_we   = 1'b1;
                pt_wa   = r_k + PW'(2);
                pt_wd   = '{r_ent.src, idx, r_ent.len - r_off};
                n_state = S_FIN;
            end
            S_RD_ST: begin
                if (!r_idx_ok) begin
                    n_rbyte = '0;
                end else if (r_ent.src) begin
                    n_rbyte = r_as_q;
                end else begin
                    n_rbyte = r_os_q;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = (r_state == S_FIN);
    assign o_res.status     = r_stat;
    assign o_res.read_byte  = r_rbyte;
    assign o_res.doc_length = r_doc;

endmodule
`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Piece table text buffer testbench
// Drives load, insert, delete and read requests through the start/busy
// handshake, predicts each result with a behavioral piece table and compares
// every o_done result field by field in request order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ptb_pkg::*;

    localparam int ORIG_N  = 4096;
    localparam int ADD_N   = 4096;
    localparam int PIECE_N = 64;
    localparam int LIMIT   = 3000000;

    typedef struct {
        bit        from_add;
        int        first;
        int        size;
    } t_piece;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_done;
    t_res o_res;

    piece_table_text_buffer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    // shadow piece table
    bit [7:0] orig_bytes[ORIG_N];
    bit [7:0] add_bytes[ADD_N];
    t_piece   pieces[PIECE_N + 2];
    int       n_pieces;
    int       orig_used;
    int       add_used;
    int       run_idx;
    bit       run_on;

    t_req     pending_reqs[$];
    t_res     expected_results[$];
    int       errors = 0;
    int       cycles = 0;
    bit       gap_free;
    bit       req_taken = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $time);
        errors++;
    endtask

    function automatic void clear_table();
        n_pieces = 1;
        pieces[0] = '{0, 0, 0};
        orig_used = 0;
        add_used = 0;
        run_idx = 0;
        run_on = 0;
    endfunction

    function automatic int doc_len();
        int s;
        s = 0;
        for (int i = 0; i < n_pieces; i++) s += pieces[i].size;
        return s;
    endfunction

    function automatic int locate(input int pos, output int off);
        int acc;
        acc = 0;
        off = 0;
        for (int i = 0; i < n_pieces; i++) begin
            if (pos < acc + pieces[i].size) begin
                off = pos - acc;
                return i;
            end
            acc += pieces[i].size;
        end
        return 0;
    endfunction

    function automatic void make_room(input int k, input int n);
        for (int i = n_pieces; i > k; i--) pieces[i - 1 + n] = pieces[i - 1];
        n_pieces += n;
    endfunction

    function automatic t_status apply_load(input bit [7:0] b, input bit restart);
        if (restart) clear_table();
        run_on = 0;
        if (orig_used >= ORIG_N || doc_len() >= DOC_MAX) return ST_BYTE_FULL;
        if (!pieces[n_pieces-1].from_add &&
            pieces[n_pieces-1].first + pieces[n_pieces-1].size == orig_used) begin
            pieces[n_pieces-1].size++;
        end else begin
            if (n_pieces >= PIECE_N) return ST_TBL_FULL;
            pieces[n_pieces] = '{0, orig_used, 1};
            n_pieces++;
        end
        orig_bytes[orig_used++] = b;
        return ST_OK;
    endfunction

    function automatic t_status apply_insert(input int pos, input bit [7:0] b,
                                             input bit restart);
        int len, k, off, at;
        bit cont;
        t_piece old;
        len = doc_len();
        cont = !restart && run_on && run_idx < n_pieces;
        if (!cont && pos > len) return ST_BAD_POS;
        if (add_used >= ADD_N || len >= DOC_MAX) return ST_BYTE_FULL;
        if (cont) begin
            pieces[run_idx].size++;
            add_bytes[add_used++] = b;
            return ST_OK;
        end
        if (pos == len) begin
            if (n_pieces + 1 > PIECE_N) return ST_TBL_FULL;
            at = n_pieces;
            n_pieces++;
        end else begin
            k = locate(pos, off);
            if (off == 0) begin
                if (n_pieces + 1 > PIECE_N) return ST_TBL_FULL;
                make_room(k, 1);
                at = k;
            end else begin
                old = pieces[k];
                if (n_pieces + 2 > PIECE_N) return ST_TBL_FULL;
                make_room(k, 2);
                pieces[k].size = off;
                pieces[k+2] = '{old.from_add, old.first + off, old.size - off};
                at = k + 1;
            end
        end
        pieces[at] = '{1, add_used, 1};
        add_bytes[add_used++] = b;
        run_idx = at;
        run_on = 1;
        return ST_OK;
    endfunction

    function automatic t_status apply_delete(input int pos);
        int k, off;
        t_piece old;
        run_on = 0;
        if (pos >= doc_len()) return ST_BAD_POS;
        k = locate(pos, off);
        old = pieces[k];
        if (off == 0) begin
            pieces[k].first++;
            pieces[k].size--;
        end else if (off == old.size - 1) begin
            pieces[k].size--;
        end else begin
            if (n_pieces + 1 > PIECE_N) return ST_TBL_FULL;
            make_room(k, 1);
            pieces[k].size = off;
            pieces[k+1].first = old.first + off + 1;
            pieces[k+1].size = old.size - off - 1;
        end
        return ST_OK;
    endfunction

    function automatic t_res predict_edit(input t_req r);
        t_res res;
        int k, off, idx;
        res = '0;
        case (t_req_type'(r.req_type))
            REQ_LOAD:   res.status = apply_load(r.data_byte, r.start_of_run);
            REQ_INSERT: res.status = apply_insert(int'(r.position), r.data_byte,
                                                  r.start_of_run);
            REQ_DELETE: res.status = apply_delete(int'(r.position));
            default: begin
                if (int'(r.position) >= doc_len()) begin
                    res.status = ST_BAD_POS;
                end else begin
                    res.status = ST_OK;
                    k = locate(int'(r.position), off);
                    idx = pieces[k].first + off;
                    res.read_byte = pieces[k].from_add ? add_bytes[idx] : orig_bytes[idx];
                end
            end
        endcase
        res.doc_length = LEN_W'(doc_len());
        return res;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_req <= '0;
        end else if (req_taken || !start) begin
            if (req_taken) void'(pending_reqs.pop_front());
            if (pending_reqs.size() > 0 && (gap_free || $urandom_range(99) >= 21)) begin
                start <= 1'b1;
                i_req <= pending_reqs[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (start && !busy) expected_results.push_back(predict_edit(i_req));
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    t_res want;
                    want = expected_results.pop_front();
                    if (o_res.status !== want.status)
                        report("status", int'(o_res.status), int'(want.status));
                    if (o_res.read_byte !== want.read_byte)
                        report("read_byte", int'(o_res.read_byte), int'(want.read_byte));
                    if (o_res.doc_length !== want.doc_length)
                        report("doc_length", int'(o_res.doc_length),
                               int'(want.doc_length));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_req mk(input t_req_type t, input int pos,
                                input int b, input bit s);
        t_req r;
        r.req_type = t;
        r.position = 13'(pos);
        r.data_byte = 8'(b);
        r.start_of_run = s;
        return r;
    endfunction

    function automatic void add_random(input int count);
        int doc;
        doc = 0;
        for (int i = 0; i < count; i++) begin
            int sel, p;
            sel = $urandom_range(99);
            p = doc > 0 ? $urandom_range(doc) : 0;
            if ($urandom_range(19) == 0) p = $urandom_range(8191);
            if (sel < 3) begin
                pending_reqs.push_back(mk(REQ_LOAD, $urandom_range(8191),
                                          $urandom_range(255), 1'b1));
                doc = 1;
            end else if (sel < 20) begin
                pending_reqs.push_back(mk(REQ_LOAD, $urandom_range(8191),
                                          $urandom_range(255), 1'b0));
                doc++;
            end else if (sel < 50) begin
                pending_reqs.push_back(mk(REQ_INSERT, p, $urandom_range(255),
                                          $urandom_range(3) == 0));
                doc++;
            end else if (sel < 65) begin
                pending_reqs.push_back(mk(REQ_DELETE, p, $urandom_range(255),
                                          $urandom_range(1) == 1));
                if (doc > 0) doc--;
            end else begin
                pending_reqs.push_back(mk(REQ_READ, p, $urandom_range(255),
                                          $urandom_range(1) == 1));
            end
        end
    endfunction

    initial begin
        i_rst_n = 1'b0;
        gap_free = 0;
        clear_table();
        // directed
        pending_reqs.push_back(mk(REQ_READ, 0, 0, 0));
        pending_reqs.push_back(mk(REQ_DELETE, 0, 0, 0));
        pending_reqs.push_back(mk(REQ_INSERT, 8191, 8'hff, 1));
        pending_reqs.push_back(mk(REQ_LOAD, 0, 8'h00, 1));
        pending_reqs.push_back(mk(REQ_LOAD, 0, 8'hff, 0));
        pending_reqs.push_back(mk(REQ_LOAD, 0, 8'h5a, 0));
        pending_reqs.push_back(mk(REQ_LOAD, 0, 8'ha5, 0));
        pending_reqs.push_back(mk(REQ_INSERT, 2, 8'h11, 1));
        pending_reqs.push_back(mk(REQ_INSERT, 8191, 8'h22, 0));
        pending_reqs.push_back(mk(REQ_INSERT, 0, 8'h33, 1));
        pending_reqs.push_back(mk(REQ_INSERT, 7, 8'h44, 1));
        pending_reqs.push_back(mk(REQ_INSERT, 3, 8'h55, 1));
        pending_reqs.push_back(mk(REQ_DELETE, 0, 0, 0));
        pending_reqs.push_back(mk(REQ_DELETE, 2, 0, 0));
        pending_reqs.push_back(mk(REQ_DELETE, 4, 0, 0));
        pending_reqs.push_back(mk(REQ_DELETE, 8191, 0, 1));
        pending_reqs.push_back(mk(REQ_LOAD, 0, 8'h77, 0));
        for (int i = 0; i < 8; i++) pending_reqs.push_back(mk(REQ_READ, i, 0, 0));
        // fill the table with splits
        for (int i = 0; i < 40; i++)
            pending_reqs.push_back(mk(REQ_INSERT, 1, i, 1));
        for (int i = 0; i < 30; i++)
            pending_reqs.push_back(mk(REQ_DELETE, 2 * i + 1, 0, 0));
        pending_reqs.push_back(mk(REQ_READ, 8191, 0, 0));
        add_random(1600);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                gap_free = 1;
                repeat (600) @(posedge i_clk);
                gap_free = 0;
            end
        join_none
        wait (pending_reqs.size() == 0 && !start);
        wait (expected_results.size() == 0);
        repeat (4 * PIECE_N + 20) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
